// ----- hw/rtl/hkrt_pkg.sv -----
`timescale 1ns / 1ps

package hkrt_pkg;

   // Array sizing and travel scale
   localparam int KEYS        = 8;
   localparam int TRAVEL_FULL = 4000;
   localparam int TRAVEL_CAP  = (TRAVEL_FULL > 4095) ? 4095 : TRAVEL_FULL;

   // Field widths
   localparam int KEY_W     = 3;
   localparam int KIDX_W    = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int SMP_W     = 16;
   localparam int TRAV_W    = 12;
   localparam int MODE_W    = 2;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 3;
   localparam int SPAN_W    = SMP_W + 1;
   localparam int TMIN_W    = 14;

   // Stream data widths
   localparam int REQ_FIELDS_W = KEY_W + 3 * SMP_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = KEY_W + 1 + TRAV_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Divider sizing: 13 quotient bits, all ones on overflow
   localparam int MAG_W    = SMP_W;
   localparam int TF_W     = $clog2(TRAVEL_FULL + 1);
   localparam int PROD_W   = MAG_W + TF_W;
   localparam int QB       = 13;
   localparam int DEN_SH_W = MAG_W + QB - 1;
   localparam int CMP_W    = (PROD_W > DEN_SH_W) ? PROD_W : DEN_SH_W;
   localparam int CNT_W    = $clog2(QB + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_DEAD_BAND   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_DEAD_BAND    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DISTANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REARM_OFFSET     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THRESHOLD  = 3'd5;

   // Trigger modes
   localparam logic [MODE_W-1:0] MODE_RAPID = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELTA = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LEVEL = 2'd2;

   // Operation codes
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_CALIBRATE = 1'b1;

   // Register reset values
   localparam logic [CSR_W-1:0] RST_HIGH_DEAD_BAND   = 12'd3000;
   localparam logic [CSR_W-1:0] RST_LOW_DEAD_BAND    = 12'd100;
   localparam logic [CSR_W-1:0] RST_RELEASE_DISTANCE = 12'd600;
   localparam logic [CSR_W-1:0] RST_REARM_OFFSET     = 12'd100;
   localparam logic [CSR_W-1:0] RST_LEVEL_THRESHOLD  = 12'd2000;

   // Divider request and response
   typedef struct packed {
      logic             start;
      logic [CMP_W-1:0] num;
      logic [MAG_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [QB-1:0] quot;
   } div_rsp_type;

endpackage

// ----- hw/rtl/hkrt_div.sv -----
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
// Quotient saturates to all ones when it does not fit in QB bits.
module hkrt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  hkrt_pkg::div_req_type     div_req,
   output hkrt_pkg::div_rsp_type     div_rsp
);

   localparam int CMP_W = hkrt_pkg::CMP_W;
   localparam int QB    = hkrt_pkg::QB;
   localparam int CNT_W = hkrt_pkg::CNT_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CMP_W-1:0] rem_ff, rem_in;
   logic [CMP_W-1:0] den_ff, den_in;
   logic [QB-1:0]    q_ff, q_in;

   // Load on start, then one compare and subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QB);
         rem_in  = div_req.num;
         den_in  = CMP_W'(div_req.den) << (QB - 1);
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff >= den_ff) begin
            rem_in = rem_ff - den_ff;
            q_in   = {q_ff[QB-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QB-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;

endmodule

// ----- hw/rtl/hall_key_rapid_trigger_core.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Ports                           Payload (lowest bit first)
// req       in   req_tvalid/tready/tdata/tuser   tuser: op; tdata: key, sample,
//                                                cal_min, cal_max
// rsp       out  rsp_tvalid/tready/tdata         out_key, pressed, travel_um,
//                                                calib_error
// csr       in   csr_wen/index/wdata             one register per index 0-5; 12-bit, mode 2-bit
//
// A sample item passes through table read, multiply, 13 steps of the shared
// divider and mode update. A new item is taken only in idle, once the previous
// one has left the update step. A calibrate item skips multiply and divider,
// and a sample on a key with zero span skips the divider. Reset is synchronous
// and clears all key state and the configuration registers. A stalled result
// waits in the output register; the next item is accepted meanwhile and holds
// in the update step until the result is taken.
module hall_key_rapid_trigger_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // key[2:0], sample[18:3], cal_min[34:19], cal_max[50:35], zero pad
   input  logic [hkrt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_key[2:0], pressed[3], travel_um[15:4], calib_error[16], zero pad
   output logic [hkrt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_wen,
   input  logic [hkrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hkrt_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int KEYS   = hkrt_pkg::KEYS;
   localparam int KEY_W  = hkrt_pkg::KEY_W;
   localparam int KIDX_W = hkrt_pkg::KIDX_W;
   localparam int SMP_W  = hkrt_pkg::SMP_W;
   localparam int TRAV_W = hkrt_pkg::TRAV_W;
   localparam int MODE_W = hkrt_pkg::MODE_W;
   localparam int CSR_W  = hkrt_pkg::CSR_W;
   localparam int SPAN_W = hkrt_pkg::SPAN_W;
   localparam int TMIN_W = hkrt_pkg::TMIN_W;
   localparam int MAG_W  = hkrt_pkg::MAG_W;
   localparam int CMP_W  = hkrt_pkg::CMP_W;
   localparam int QB     = hkrt_pkg::QB;
   localparam int RSP_PAD_W = hkrt_pkg::RSP_TDATA_W - hkrt_pkg::RSP_FIELDS_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_UPD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [CSR_W-1:0]  hdb_ff, ldb_ff, rel_ff, rearm_ff, lvl_ff;

   // Item fields
   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SMP_W-1:0]  smp_ff, cmin_ff, cmax_ff;

   // Per-key state
   logic [SMP_W-1:0]  last_ff  [KEYS];
   logic [TMIN_W-1:0] tmin_ff  [KEYS];
   logic [TRAV_W-1:0] prior_ff [KEYS];
   logic              down_ff  [KEYS];
   logic [SMP_W-1:0]  low_ff   [KEYS];
   logic [SPAN_W-1:0] span_ff  [KEYS];

   // Key state read for the current item
   logic [SMP_W-1:0]  rd_last_ff;
   logic [TMIN_W-1:0] rd_tmin_ff;
   logic [TRAV_W-1:0] rd_prior_ff;
   logic              rd_down_ff;
   logic [SMP_W-1:0]  rd_low_ff;
   logic [SPAN_W-1:0] rd_span_ff;

   logic              pos_ff;
   logic [TRAV_W-1:0] travel_ff;

   logic                                rsp_valid_ff;
   logic [hkrt_pkg::RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   hkrt_pkg::div_req_type div_req;
   hkrt_pkg::div_rsp_type div_rsp;

   logic              key_ok;
   logic [KIDX_W-1:0] kidx;
   logic              accept;
   logic              upd_go;
   logic              span_zero;

   logic [SMP_W:0]    avg_sum;
   logic [SMP_W-1:0]  avg;
   logic [SPAN_W-1:0] diff;
   logic [MAG_W-1:0]  diff_mag, span_mag;

   logic [SPAN_W-1:0] span_new;
   logic              new_down;
   logic [TMIN_W-1:0] new_tmin;
   logic [TRAV_W-1:0] new_prior;
   logic [TRAV_W-1:0] out_travel;
   logic              out_err;
   logic              out_pressed;
   logic signed [TMIN_W:0] travel_s, tmin_s, rel_sum;

   assign key_ok     = (int'(key_ff) < KEYS);
   assign kidx       = KIDX_W'(key_ff);
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign upd_go     = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_tready);
   assign span_zero  = (rd_span_ff == '0);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: begin
            if (!key_ok || op_ff == hkrt_pkg::OP_CALIBRATE) state_in = S_UPD;
            else state_in = S_MUL;
         end
         S_MUL: begin
            if (span_zero) state_in = S_UPD;
            else state_in = S_DIV;
         end
         S_DIV: if (div_rsp.done) state_in = S_UPD;
         S_UPD: if (upd_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= hkrt_pkg::MODE_RAPID;
         hdb_ff   <= hkrt_pkg::RST_HIGH_DEAD_BAND;
         ldb_ff   <= hkrt_pkg::RST_LOW_DEAD_BAND;
         rel_ff   <= hkrt_pkg::RST_RELEASE_DISTANCE;
         rearm_ff <= hkrt_pkg::RST_REARM_OFFSET;
         lvl_ff   <= hkrt_pkg::RST_LEVEL_THRESHOLD;
      end else if (csr_wen) begin
         case (csr_index)
            hkrt_pkg::CSR_TRIGGER_MODE:     mode_ff  <= csr_wdata[MODE_W-1:0];
            hkrt_pkg::CSR_HIGH_DEAD_BAND:   hdb_ff   <= csr_wdata;
            hkrt_pkg::CSR_LOW_DEAD_BAND:    ldb_ff   <= csr_wdata;
            hkrt_pkg::CSR_RELEASE_DISTANCE: rel_ff   <= csr_wdata;
            hkrt_pkg::CSR_REARM_OFFSET:     rearm_ff <= csr_wdata;
            hkrt_pkg::CSR_LEVEL_THRESHOLD:  lvl_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture item, read key state, latch travel
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser;
         key_ff  <= req_tdata[KEY_W-1:0];
         smp_ff  <= req_tdata[KEY_W +: SMP_W];
         cmin_ff <= req_tdata[KEY_W + SMP_W +: SMP_W];
         cmax_ff <= req_tdata[KEY_W + 2 * SMP_W +: SMP_W];
      end
      if (state_ff == S_READ) begin
         rd_last_ff  <= last_ff[kidx];
         rd_tmin_ff  <= tmin_ff[kidx];
         rd_prior_ff <= prior_ff[kidx];
         rd_down_ff  <= down_ff[kidx];
         rd_low_ff   <= low_ff[kidx];
         rd_span_ff  <= span_ff[kidx];
      end
      if (state_ff == S_MUL) begin
         pos_ff <= (diff[SPAN_W-1] == rd_span_ff[SPAN_W-1]);
      end
      if (state_ff == S_DIV && div_rsp.done) begin
         if (!pos_ff) travel_ff <= '0;
         else if (div_rsp.quot > QB'(hkrt_pkg::TRAVEL_CAP))
            travel_ff <= TRAV_W'(hkrt_pkg::TRAVEL_CAP);
         else travel_ff <= div_rsp.quot[TRAV_W-1:0];
      end
   end

   // Average, offset and scale for the divider
   always_comb begin
      avg_sum  = {1'b0, rd_last_ff} + {1'b0, smp_ff};
      avg      = avg_sum[SMP_W:1];
      diff     = {1'b0, avg} - {1'b0, rd_low_ff};
      diff_mag = diff[SPAN_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
      span_mag = rd_span_ff[SPAN_W-1] ? MAG_W'(-rd_span_ff) : rd_span_ff[MAG_W-1:0];
   end

   assign div_req.start = (state_ff == S_MUL) && !span_zero;
   assign div_req.num   = CMP_W'(diff_mag) * CMP_W'(hkrt_pkg::TRAVEL_FULL);
   assign div_req.den   = span_mag;

   hkrt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Trigger mode update and result fields
   always_comb begin
      span_new    = {1'b0, cmax_ff} - {1'b0, cmin_ff};
      travel_s    = $signed({{(TMIN_W + 1 - TRAV_W){1'b0}}, travel_ff});
      tmin_s      = $signed({rd_tmin_ff[TMIN_W-1], rd_tmin_ff});
      rel_sum     = tmin_s + $signed({{(TMIN_W + 1 - CSR_W){1'b0}}, rel_ff});
      new_down    = rd_down_ff;
      new_tmin    = rd_tmin_ff;
      new_prior   = rd_prior_ff;
      out_travel  = '0;
      out_err     = 1'b0;
      out_pressed = rd_down_ff;
      if (!key_ok) begin
         out_pressed = 1'b0;
      end else if (op_ff == hkrt_pkg::OP_CALIBRATE) begin
         out_err = (span_new == '0);
      end else if (span_zero) begin
         out_err = 1'b1;
      end else begin
         out_travel = travel_ff;
         case (mode_ff)
            hkrt_pkg::MODE_RAPID: begin
               if (travel_ff < hdb_ff && tmin_s >= travel_s) begin
                  new_tmin = TMIN_W'(travel_ff);
                  new_down = 1'b1;
               end else if (travel_ff > ldb_ff && rel_sum < travel_s) begin
                  new_tmin = TMIN_W'(travel_ff) - TMIN_W'(rearm_ff);
                  new_down = 1'b0;
               end
            end
            hkrt_pkg::MODE_DELTA: begin
               if (!rd_down_ff && travel_ff > rd_prior_ff) new_down = 1'b1;
               else if (rd_down_ff && travel_ff < rd_prior_ff) new_down = 1'b0;
               new_prior = travel_ff;
            end
            hkrt_pkg::MODE_LEVEL: new_down = (travel_ff <= lvl_ff);
            default: ;
         endcase
         out_pressed = new_down;
      end
      rsp_data_in = {{RSP_PAD_W{1'b0}}, out_err, out_travel, out_pressed, key_ff};
   end

   // Key state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEYS; i++) begin
            last_ff[i]  <= '0;
            tmin_ff[i]  <= '0;
            prior_ff[i] <= '0;
            down_ff[i]  <= 1'b0;
            low_ff[i]   <= '0;
            span_ff[i]  <= '0;
         end
      end else if (upd_go && key_ok) begin
         if (op_ff == hkrt_pkg::OP_CALIBRATE) begin
            low_ff[kidx]  <= cmin_ff;
            span_ff[kidx] <= span_new;
         end else begin
            last_ff[kidx]  <= smp_ff;
            tmin_ff[kidx]  <= new_tmin;
            prior_ff[kidx] <= new_prior;
            down_ff[kidx]  <= new_down;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/hkrt_checker.sv -----
`timescale 1ns / 1ps

module hkrt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hkrt_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int TRAV_LO = hkrt_pkg::KEY_W + 1;
   localparam int ERR_BIT = TRAV_LO + hkrt_pkg::TRAV_W;

   logic [hkrt_pkg::TRAV_W-1:0] travel;
   logic                        err;

   assign travel = rsp_tdata[TRAV_LO +: hkrt_pkg::TRAV_W];
   assign err    = rsp_tdata[ERR_BIT];

   // One item at a time: no accept right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item in work");

   // Travel never exceeds the full-travel clamp
   a_travel_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> travel <= hkrt_pkg::TRAV_W'(hkrt_pkg::TRAVEL_CAP))
      else $error("travel above clamp");

   // Zero span reports no travel
   a_err_no_travel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err |-> travel == '0)
      else $error("calibration error with nonzero travel");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind hall_key_rapid_trigger_core hkrt_checker u_hkrt_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int KEYS        = hkrt_pkg::KEYS;
   localparam int KEY_W       = hkrt_pkg::KEY_W;
   localparam int SMP_W       = hkrt_pkg::SMP_W;
   localparam int TRAV_W      = hkrt_pkg::TRAV_W;
   localparam int MODE_W      = hkrt_pkg::MODE_W;
   localparam int CSR_W       = hkrt_pkg::CSR_W;
   localparam int CSR_IDX_W   = hkrt_pkg::CSR_IDX_W;
   localparam int SPAN_W      = hkrt_pkg::SPAN_W;
   localparam int TMIN_W      = hkrt_pkg::TMIN_W;
   localparam int TRAVEL_FULL = hkrt_pkg::TRAVEL_FULL;
   localparam int TRAVEL_CAP  = hkrt_pkg::TRAVEL_CAP;
   localparam int REQ_TDATA_W = hkrt_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = hkrt_pkg::RSP_TDATA_W;

   // Mode code the block leaves unused: keys hold their state
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 60;

   // Result field positions in rsp_tdata
   localparam int PRESSED_BIT = KEY_W;
   localparam int TRAVEL_LSB  = KEY_W + 1;
   localparam int ERROR_BIT   = KEY_W + 1 + TRAV_W;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              pressed;
      logic [TRAV_W-1:0] travel;
      logic              calib_error;
   } key_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_W-1:0]       csr_wdata  = '0;

   // Shadow registers and per-key state of the predictor
   logic [MODE_W-1:0]        cfg_mode;
   logic [CSR_W-1:0]         cfg_high_band;
   logic [CSR_W-1:0]         cfg_low_band;
   logic [CSR_W-1:0]         cfg_release;
   logic [CSR_W-1:0]         cfg_rearm;
   logic [CSR_W-1:0]         cfg_level;
   logic [SMP_W-1:0]         prev_sample [KEYS];
   logic signed [TMIN_W-1:0] min_travel  [KEYS];
   logic [TRAV_W-1:0]        last_travel [KEYS];
   logic                     key_down    [KEYS];
   logic [SMP_W-1:0]         cal_low     [KEYS];
   logic signed [SPAN_W-1:0] cal_span    [KEYS];

   key_result_type expected_key_results [$];

   bit steady = 1'b0;
   int ready_hold = 0;
   int idle_cycles = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int calib_items = 0;
   int zero_span_samples = 0;
   int settings_applied = 0;
   int results_seen = 0;
   int presses = 0;
   int releases = 0;

   hall_key_rapid_trigger_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Travel and pressed flag for one item; updates the key state
   function automatic key_result_type predict_key_result(logic op, logic [KEY_W-1:0] k,
         logic [SMP_W-1:0] smp, logic [SMP_W-1:0] cmin, logic [SMP_W-1:0] cmax);
      key_result_type res;
      logic [SMP_W:0] avg;
      logic was_down;
      longint num;
      longint quo;
      int travel;
      int floor_v;
      int delta;
      res = '0;
      res.key = k;
      travel = 0;
      was_down = key_down[k];
      if (op == hkrt_pkg::OP_CALIBRATE) begin
         cal_low[k] = cmin;
         cal_span[k] = SPAN_W'(int'(cmax) - int'(cmin));
         res.calib_error = (cal_span[k] == 0);
         calib_items++;
      end else begin
         avg = ({1'b0, prev_sample[k]} + {1'b0, smp}) >> 1;
         prev_sample[k] = smp;
         if (cal_span[k] == 0) begin
            // zero span: flag it, hold the trigger state
            res.calib_error = 1'b1;
            zero_span_samples++;
         end else begin
            num = (longint'(avg) - longint'(cal_low[k])) * TRAVEL_FULL;
            quo = num / longint'(cal_span[k]);
            if (quo < 0) quo = 0;
            if (quo > TRAVEL_CAP) quo = TRAVEL_CAP;
            travel = int'(quo);
            case (cfg_mode)
               hkrt_pkg::MODE_RAPID: begin
                  floor_v = int'(min_travel[k]);
                  if (travel < int'(cfg_high_band) && floor_v >= travel) begin
                     min_travel[k] = TMIN_W'(travel);
                     key_down[k] = 1'b1;
                  end else if (travel > int'(cfg_low_band) &&
                               floor_v + int'(cfg_release) < travel) begin
                     min_travel[k] = TMIN_W'(travel - int'(cfg_rearm));
                     key_down[k] = 1'b0;
                  end
               end
               hkrt_pkg::MODE_DELTA: begin
                  delta = travel - int'(last_travel[k]);
                  if (!key_down[k]) begin
                     if (delta >= 1) key_down[k] = 1'b1;
                  end else begin
                     if (delta <= -1) key_down[k] = 1'b0;
                  end
                  last_travel[k] = TRAV_W'(travel);
               end
               hkrt_pkg::MODE_LEVEL: begin
                  key_down[k] = (travel <= int'(cfg_level));
               end
               default: begin
               end
            endcase
         end
      end
      if (!was_down && key_down[k]) presses++;
      if (was_down && !key_down[k]) releases++;
      res.pressed = key_down[k];
      res.travel = TRAV_W'(travel);
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Send one item, with an occasional gap; predict it once accepted
   task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [SMP_W-1:0] smp,
         logic [SMP_W-1:0] cmin, logic [SMP_W-1:0] cmax);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({cmax, cmin, smp, k});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_key_results.push_back(predict_key_result(op, k, smp, cmin, cmax));
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_key_results.size() != 0) @(posedge clock);
   endtask

   // One register write; csr_wen is lowered by the caller
   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         hkrt_pkg::CSR_TRIGGER_MODE:     cfg_mode      = val[MODE_W-1:0];
         hkrt_pkg::CSR_HIGH_DEAD_BAND:   cfg_high_band = val;
         hkrt_pkg::CSR_LOW_DEAD_BAND:    cfg_low_band  = val;
         hkrt_pkg::CSR_RELEASE_DISTANCE: cfg_release   = val;
         hkrt_pkg::CSR_REARM_OFFSET:     cfg_rearm     = val;
         hkrt_pkg::CSR_LEVEL_THRESHOLD:  cfg_level     = val;
         default: begin
         end
      endcase
   endtask

   // Drain, then write every register
   task automatic apply_settings(logic [CSR_W-1:0] mode, logic [CSR_W-1:0] high_band,
         logic [CSR_W-1:0] low_band, logic [CSR_W-1:0] rel, logic [CSR_W-1:0] rearm,
         logic [CSR_W-1:0] level);
      wait_for_results();
      csr_put(hkrt_pkg::CSR_TRIGGER_MODE, mode);
      csr_put(hkrt_pkg::CSR_HIGH_DEAD_BAND, high_band);
      csr_put(hkrt_pkg::CSR_LOW_DEAD_BAND, low_band);
      csr_put(hkrt_pkg::CSR_RELEASE_DISTANCE, rel);
      csr_put(hkrt_pkg::CSR_REARM_OFFSET, rearm);
      csr_put(hkrt_pkg::CSR_LEVEL_THRESHOLD, level);
      csr_wen <= 1'b0;
      settings_applied++;
   endtask

   // Converter value that gives roughly this travel on key k, with jitter
   function automatic logic [SMP_W-1:0] sample_at_travel(int k, int travel);
      longint raw;
      raw = longint'(cal_low[k]) + longint'(cal_span[k]) * travel / TRAVEL_FULL
            + longint'($urandom_range(0, 4)) - 2;
      if (raw < 0) raw = 0;
      if (raw > 65535) raw = 65535;
      return SMP_W'(raw);
   endfunction

   task automatic calibrate_key(logic [KEY_W-1:0] k);
      int lo;
      int hi;
      int span;
      lo = int'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0: span = int'($urandom_range(0, 65535)) - lo;
         1: span = 0;
         2: span = ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 8))
                                                : -int'($urandom_range(1, 8));
         default: span = ($urandom_range(0, 3) != 0) ? int'($urandom_range(200, 30000))
                                                     : -int'($urandom_range(200, 30000));
      endcase
      hi = lo + span;
      if (hi < 0) hi = 0;
      if (hi > 65535) hi = 65535;
      send_item(hkrt_pkg::OP_CALIBRATE, k, SMP_W'($urandom_range(0, 65535)),
                SMP_W'(lo), SMP_W'(hi));
   endtask

   // Key strokes: ramps of travel between random depths, calibration now and then
   task automatic run_strokes(int n);
      int done_items;
      int t_from;
      int t_to;
      int steps;
      logic [KEY_W-1:0] k;
      done_items = 0;
      while (done_items < n) begin
         k = KEY_W'($urandom_range(0, KEYS - 1));
         if (cal_span[k] == 0 || $urandom_range(0, 15) == 0) begin
            calibrate_key(k);
            done_items++;
         end else begin
            t_from = int'($urandom_range(0, 4400)) - 200;
            t_to   = int'($urandom_range(0, 4400)) - 200;
            steps  = int'($urandom_range(2, 8));
            for (int i = 0; i <= steps; i++) begin
               send_item(hkrt_pkg::OP_SAMPLE, k,
                         sample_at_travel(int'(k), t_from + (t_to - t_from) * i / steps),
                         SMP_W'($urandom_range(0, 65535)),
                         SMP_W'($urandom_range(0, 65535)));
               done_items++;
            end
         end
         // sender holds off until the block has answered everything
         if ($urandom_range(0, 63) == 0) wait_for_results();
      end
   endtask

   task automatic test_directed_corners();
      // key never calibrated
      send_item(hkrt_pkg::OP_SAMPLE, 3'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
      // equal ends give a zero span; the sample still updates last sample
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd0, 16'h0000, 16'h1234, 16'h1234);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd0, 16'h0000, 16'hFFFF, 16'h0000);
      // full positive span: bottom, middle, top
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd0, 16'h0000, 16'hAAAA, 16'h5555);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd0, 16'hFFFF, 16'h5555, 16'hAAAA);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd0, 16'hFFFF, 16'h0000, 16'h0000);
      // full negative span
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd7, 16'h0000, 16'hFFFF, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd7, 16'h0000, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd7, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd7, 16'hFFFF, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd7, 16'hFFFF, 16'h0000, 16'h0000);
      // span of one: quotient far beyond full travel, and below zero
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd2, 16'h0000, 16'd8000, 16'd8001);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd2, 16'd8001, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd2, 16'd8001, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd2, 16'd7999, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd2, 16'hFFFF, 16'h0000, 16'h0000);
      // span of minus one
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd3, 16'h0000, 16'd100, 16'd99);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd3, 16'd50, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd3, 16'd200, 16'h0000, 16'h0000);
      // zero span, then recalibrate: average uses the sample taken meanwhile
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd4, 16'h0000, 16'd500, 16'd500);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd4, 16'h5555, 16'h0000, 16'h0000);
      send_item(hkrt_pkg::OP_CALIBRATE, 3'd4, 16'h0000, 16'h0000, 16'hAAAA);
      send_item(hkrt_pkg::OP_SAMPLE, 3'd4, 16'hAAAA, 16'h0000, 16'h0000);
   endtask

   task automatic test_register_extremes();
      apply_settings(CSR_W'(hkrt_pkg::MODE_RAPID), 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      run_strokes(60);
      // all ones: upper mode bits are dropped
      apply_settings({10'h3FF, hkrt_pkg::MODE_RAPID}, 12'hFFF, 12'hFFF, 12'hFFF,
                     12'hFFF, 12'hFFF);
      run_strokes(60);
      apply_settings(CSR_W'(hkrt_pkg::MODE_LEVEL), hkrt_pkg::RST_HIGH_DEAD_BAND,
                     hkrt_pkg::RST_LOW_DEAD_BAND, hkrt_pkg::RST_RELEASE_DISTANCE,
                     hkrt_pkg::RST_REARM_OFFSET, 12'd0);
      run_strokes(60);
      apply_settings({10'h3FF, hkrt_pkg::MODE_LEVEL}, hkrt_pkg::RST_HIGH_DEAD_BAND,
                     hkrt_pkg::RST_LOW_DEAD_BAND, hkrt_pkg::RST_RELEASE_DISTANCE,
                     hkrt_pkg::RST_REARM_OFFSET, 12'hFFF);
      run_strokes(60);
   endtask

   task automatic test_trigger_modes();
      logic [MODE_W-1:0] modes [4];
      modes = '{hkrt_pkg::MODE_RAPID, hkrt_pkg::MODE_DELTA, hkrt_pkg::MODE_LEVEL,
                MODE_UNUSED};
      foreach (modes[m]) begin
         apply_settings(CSR_W'(modes[m]), hkrt_pkg::RST_HIGH_DEAD_BAND,
                        hkrt_pkg::RST_LOW_DEAD_BAND, hkrt_pkg::RST_RELEASE_DISTANCE,
                        hkrt_pkg::RST_REARM_OFFSET, hkrt_pkg::RST_LEVEL_THRESHOLD);
         run_strokes(120);
      end
   endtask

   function automatic logic [CSR_W-1:0] random_band();
      if ($urandom_range(0, 7) == 0) return CSR_W'($urandom_range(0, 4095));
      return CSR_W'($urandom_range(0, TRAVEL_FULL));
   endfunction

   task automatic random_settings();
      logic [MODE_W-1:0] modes [4];
      modes = '{hkrt_pkg::MODE_RAPID, hkrt_pkg::MODE_DELTA, hkrt_pkg::MODE_LEVEL,
                MODE_UNUSED};
      apply_settings(CSR_W'(modes[$urandom_range(0, 3)]), random_band(), random_band(),
                     random_band(), random_band(), random_band());
   endtask

   task automatic test_random_settings();
      repeat (5) begin
         random_settings();
         run_strokes(100);
      end
   endtask

   // Unstructured items: any op, key and field values
   task automatic test_noise_items();
      random_settings();
      repeat (200) begin
         send_item(($urandom_range(0, 3) == 0) ? hkrt_pkg::OP_CALIBRATE
                                               : hkrt_pkg::OP_SAMPLE,
                   KEY_W'($urandom_range(0, KEYS - 1)), SMP_W'($urandom_range(0, 65535)),
                   SMP_W'($urandom_range(0, 65535)), SMP_W'($urandom_range(0, 65535)));
      end
   endtask

   // Back-to-back items, result side always ready
   task automatic test_steady_stream();
      random_settings();
      steady = 1'b1;
      run_strokes(200);
   endtask

   // Result-side stalls in random bursts, none in the steady test
   always @(posedge clock) begin
      if (steady) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         ready_hold <= int'($urandom_range(0, 4));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_key_results.size() == 0) begin
            report_mismatch("unexpected result, key", int'(rsp_tdata[KEY_W-1:0]), -1);
         end else begin
            want = expected_key_results.pop_front();
            if (rsp_tdata[KEY_W-1:0] != want.key)
               report_mismatch("out_key", int'(rsp_tdata[KEY_W-1:0]), int'(want.key));
            if (rsp_tdata[PRESSED_BIT] != want.pressed)
               report_mismatch("pressed", int'(rsp_tdata[PRESSED_BIT]), int'(want.pressed));
            if (rsp_tdata[TRAVEL_LSB +: TRAV_W] != want.travel)
               report_mismatch("travel_um", int'(rsp_tdata[TRAVEL_LSB +: TRAV_W]),
                               int'(want.travel));
            if (rsp_tdata[ERROR_BIT] != want.calib_error)
               report_mismatch("calib_error", int'(rsp_tdata[ERROR_BIT]),
                               int'(want.calib_error));
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_key_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      cfg_mode      = hkrt_pkg::MODE_RAPID;
      cfg_high_band = hkrt_pkg::RST_HIGH_DEAD_BAND;
      cfg_low_band  = hkrt_pkg::RST_LOW_DEAD_BAND;
      cfg_release   = hkrt_pkg::RST_RELEASE_DISTANCE;
      cfg_rearm     = hkrt_pkg::RST_REARM_OFFSET;
      cfg_level     = hkrt_pkg::RST_LEVEL_THRESHOLD;
      for (int i = 0; i < KEYS; i++) begin
         prev_sample[i] = '0;
         min_travel[i]  = '0;
         last_travel[i] = '0;
         key_down[i]    = 1'b0;
         cal_low[i]     = '0;
         cal_span[i]    = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_register_extremes();
      test_trigger_modes();
      test_random_settings();
      test_noise_items();
      test_steady_stream();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items (%0d calibrations, %0d zero-span samples) over %0d settings",
               items_sent, calib_items, zero_span_samples, settings_applied);
      $display("Checked %0d results; %0d presses and %0d releases predicted",
               results_seen, presses, releases);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
